// File: hw/rtl/tlpts_pkg.sv
// ----------------------------------------------------------------------------
// Two-level priority thread scheduler package
// Shared constants, event and status codes, and the result flag group.
// ----------------------------------------------------------------------------
package tlpts_pkg;

  localparam int THREADS_DEFAULT = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_EXIT   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DONE = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    switched;
    logic    preempted;
  } result_flags_t;

endpackage

// File: hw/rtl/tlpts_fifo.sv
// ----------------------------------------------------------------------------
// Slot queue
// Circular queue of slot numbers with head and count, push and pop per cycle.
// ----------------------------------------------------------------------------
module tlpts_fifo #(
  parameter int DEPTH = tlpts_pkg::THREADS_DEFAULT,
  localparam int W    = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic [W-1:0]  head_data,
  output logic [CW-1:0] count
);

  localparam int SW = W + 1;

  logic [W-1:0]  ent [DEPTH];
  logic [W-1:0]  head;
  logic [W-1:0]  head_next;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [W-1:0]  tail;
  logic          push_ok;

  assign push_ok   = push && (count < CW'(DEPTH));
  assign tail_sum  = {1'b0, head} + SW'(count);
  assign tail      = (tail_sum >= SW'(DEPTH)) ? W'(tail_sum - SW'(DEPTH)) : W'(tail_sum);
  assign head_data = ent[head];

  always_comb begin
    head_next  = head;
    count_next = count;
    if (pop) begin
      head_next = (head == W'(DEPTH - 1)) ? '0 : head + W'(1);
    end
    if (push_ok && !pop) begin
      count_next = count + CW'(1);
    end else if (!push_ok && pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent[tail] <= push_data;
    end
  end

endmodule

// File: hw/rtl/tlpts_core.sv
// ----------------------------------------------------------------------------
// Scheduler core
// Slot tables, run queues, quantum counter and the per-event decision logic.
// ----------------------------------------------------------------------------
module tlpts_core #(
  parameter int THREADS = tlpts_pkg::THREADS_DEFAULT,
  localparam int SLOT_W = $clog2(THREADS),
  localparam int CW     = $clog2(THREADS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_data,
  input  logic                      fire,
  input  logic [1:0]                func,
  input  logic                      priority_req,
  output tlpts_pkg::result_flags_t  flags,
  output logic [SLOT_W-1:0]         new_slot,
  output logic [SLOT_W-1:0]         running_slot,
  output logic [SLOT_W-1:0]         previous_slot
);

  logic [15:0]        quantum;
  logic [THREADS-1:0] slot_used;
  logic [THREADS-1:0] slot_used_next;
  logic [THREADS-1:0] slot_high;
  logic [THREADS-1:0] slot_high_next;
  logic [SLOT_W-1:0]  current_slot;
  logic [SLOT_W-1:0]  current_slot_next;
  logic [15:0]        ticks_left;
  logic [15:0]        ticks_left_next;
  logic [15:0]        tick_dec;
  logic               all_done;
  logic               all_done_next;

  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;

  logic               hi_push;
  logic               hi_pop;
  logic [SLOT_W-1:0]  hi_push_data;
  logic [SLOT_W-1:0]  hi_head;
  logic [CW-1:0]      hi_count;
  logic               lo_push;
  logic               lo_pop;
  logic [SLOT_W-1:0]  lo_push_data;
  logic [SLOT_W-1:0]  lo_head;
  logic [CW-1:0]      lo_count;

  tlpts_fifo #(.DEPTH(THREADS)) u_high_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (hi_push),
    .push_data (hi_push_data),
    .pop       (hi_pop),
    .head_data (hi_head),
    .count     (hi_count)
  );

  tlpts_fifo #(.DEPTH(THREADS)) u_low_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (lo_push),
    .push_data (lo_push_data),
    .pop       (lo_pop),
    .head_data (lo_head),
    .count     (lo_count)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign tick_dec = ticks_left - 16'd1;

  always_comb begin
    slot_used_next    = slot_used;
    slot_high_next    = slot_high;
    current_slot_next = current_slot;
    ticks_left_next   = ticks_left;
    all_done_next     = all_done;
    hi_push           = 1'b0;
    hi_pop            = 1'b0;
    hi_push_data      = free_idx;
    lo_push           = 1'b0;
    lo_pop            = 1'b0;
    lo_push_data      = current_slot;
    flags.status      = tlpts_pkg::STATUS_OK;
    flags.switched    = 1'b0;
    flags.preempted   = 1'b0;
    new_slot          = '0;
    if (fire) begin
      if (all_done) begin
        flags.status = tlpts_pkg::STATUS_DONE;
      end else begin
        case (tlpts_pkg::func_t'(func))
          tlpts_pkg::FUNC_CREATE: begin
            if (!free_found) begin
              flags.status = tlpts_pkg::STATUS_FULL;
            end else begin
              slot_used_next[free_idx] = 1'b1;
              slot_high_next[free_idx] = priority_req;
              hi_push                  = priority_req;
              lo_push                  = !priority_req;
              lo_push_data             = free_idx;
              new_slot                 = free_idx;
            end
          end
          tlpts_pkg::FUNC_TICK: begin
            if (!slot_high[current_slot]) begin
              ticks_left_next = tick_dec;
              if (hi_count != '0) begin
                lo_push           = 1'b1;
                hi_pop            = 1'b1;
                current_slot_next = hi_head;
                if (!slot_high[hi_head]) begin
                  ticks_left_next = quantum;
                end
                flags.switched  = 1'b1;
                flags.preempted = 1'b1;
              end else if (tick_dec == 16'd0) begin
                ticks_left_next = quantum;
                if (lo_count != '0) begin
                  lo_push           = 1'b1;
                  lo_pop            = 1'b1;
                  current_slot_next = lo_head;
                  flags.switched    = 1'b1;
                end
              end
            end
          end
          tlpts_pkg::FUNC_EXIT: begin
            slot_used_next[current_slot] = 1'b0;
            if (hi_count != '0) begin
              hi_pop            = 1'b1;
              current_slot_next = hi_head;
              if (!slot_high[hi_head]) begin
                ticks_left_next = quantum;
              end
              flags.switched = 1'b1;
            end else if (lo_count != '0) begin
              lo_pop            = 1'b1;
              current_slot_next = lo_head;
              if (!slot_high[lo_head]) begin
                ticks_left_next = quantum;
              end
              flags.switched = 1'b1;
            end else begin
              all_done_next = 1'b1;
              flags.status  = tlpts_pkg::STATUS_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign running_slot  = current_slot_next;
  assign previous_slot = current_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum      <= tlpts_pkg::QUANTUM_RESET;
      slot_used    <= THREADS'(1);
      slot_high    <= '0;
      current_slot <= '0;
      ticks_left   <= tlpts_pkg::QUANTUM_RESET;
      all_done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_data;
      end
      slot_used    <= slot_used_next;
      slot_high    <= slot_high_next;
      current_slot <= current_slot_next;
      ticks_left   <= ticks_left_next;
      all_done     <= all_done_next;
    end
  end

endmodule

// File: hw/rtl/tlpts_skid.sv
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage, so a stalled receiver costs no input slot.
// ----------------------------------------------------------------------------
module tlpts_skid #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [DATA_W-1:0] in_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_data
);

  logic              main_valid;
  logic [DATA_W-1:0] main_data;
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && out_stall) begin
      if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      main_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid && out_stall) begin
      if (in_fire) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      main_data <= skid_data;
    end else begin
      main_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/two_level_priority_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Two-level priority thread scheduler
// Fixed-priority preemption over round robin for a set of thread slots.
// ----------------------------------------------------------------------------
// Events arrive on the request channel (func, priority_req) under req_valid
// and req_stall; a transaction completes when valid is high and stall is low.
// Each event gives exactly one result on the response channel (status,
// new_slot, switched, preempted, running_slot, previous_slot) under rsp_valid
// and rsp_stall. The user must write the quantum through cfg_we and cfg_data
// only while the block is idle; the block does not enforce this. It applies
// at the next reload of the tick counter. An event is decided in the cycle it
// is accepted and its result is registered. One event is taken every cycle
// while req_stall is low; the lowest free slot search and the queue push and
// pop set that rate. When the receiver stalls, one further result is held in
// a skid stage and req_stall then rises until the output register drains.
// Reset frees every slot but slot zero, which runs at low priority, empties
// both queues, loads the quantum with ten ticks and clears the finished state.
// ----------------------------------------------------------------------------
module two_level_priority_thread_scheduler #(
  parameter int THREADS = tlpts_pkg::THREADS_DEFAULT,
  localparam int SLOT_W = $clog2(THREADS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        func,
  input  logic              priority_req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] new_slot,
  output logic              switched,
  output logic              preempted,
  output logic [SLOT_W-1:0] running_slot,
  output logic [SLOT_W-1:0] previous_slot
);

  localparam int FLAGS_W = $bits(tlpts_pkg::result_flags_t);
  localparam int DATA_W  = FLAGS_W + 3 * SLOT_W;

  logic                     fire;
  tlpts_pkg::result_flags_t core_flags;
  tlpts_pkg::result_flags_t rsp_flags;
  logic [SLOT_W-1:0]        core_new_slot;
  logic [SLOT_W-1:0]        core_running_slot;
  logic [SLOT_W-1:0]        core_previous_slot;
  logic [DATA_W-1:0]        rsp_data;

  assign fire = req_valid && !req_stall;

  tlpts_core #(.THREADS(THREADS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fire          (fire),
    .func          (func),
    .priority_req  (priority_req),
    .flags         (core_flags),
    .new_slot      (core_new_slot),
    .running_slot  (core_running_slot),
    .previous_slot (core_previous_slot)
  );

  tlpts_skid #(.DATA_W(DATA_W)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (fire),
    .in_data   ({core_flags, core_new_slot, core_running_slot, core_previous_slot}),
    .full      (req_stall),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_data  (rsp_data)
  );

  assign rsp_flags     = tlpts_pkg::result_flags_t'(rsp_data[DATA_W-1 -: FLAGS_W]);
  assign status        = rsp_flags.status;
  assign switched      = rsp_flags.switched;
  assign preempted     = rsp_flags.preempted;
  assign new_slot      = rsp_data[3*SLOT_W-1 -: SLOT_W];
  assign running_slot  = rsp_data[2*SLOT_W-1 -: SLOT_W];
  assign previous_slot = rsp_data[SLOT_W-1:0];

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no result waiting");

  a_preempt_is_switch: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && preempted) |-> switched)
    else $error("preemption reported without a switch");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == tlpts_pkg::STATUS_FULL) |->
      (new_slot == '0 && !switched && running_slot == previous_slot))
    else $error("full create changed the running thread or gave a slot");

  a_done_no_switch: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == tlpts_pkg::STATUS_DONE) |->
      (!switched && !preempted && running_slot == previous_slot))
    else $error("finished status reported with a thread switch");

endmodule
